// File: sv/selt_pkg.sv
// Package for the shared/exclusive lock table: opcodes, verdict codes,
// item record layout and default table sizes. No dependencies.
package selt_pkg;

  // Field widths fixed by the interface
  localparam int ID_W     = 10;
  localparam int OP_W     = 2;
  localparam int VERDICT_W = 2;
  localparam int OWNER_W  = 11;
  // Ids widened to this before slicing down to a table index
  localparam int ID_EXT_W = 17;

  // Default table depths
  localparam int ITEMS_DEF        = 1024;
  localparam int TRANSACTIONS_DEF = 1024;

  // Opcodes
  localparam logic [OP_W-1:0] OP_SHARED = 2'd0;
  localparam logic [OP_W-1:0] OP_EXCL   = 2'd1;
  localparam logic [OP_W-1:0] OP_END    = 2'd2;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_GRANTED = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DENIED  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_IGNORED = 2'd2;

  // Owner code for an item held by several transactions
  localparam logic [OWNER_W-1:0] OWNER_SEVERAL = 11'h400;

  // One item record as kept in the item table
  typedef struct packed {
    logic               in_use;
    logic               has_excl;
    logic               has_shared;
    logic [OWNER_W-1:0] owner;
  } item_rec_t;

endpackage

// File: sv/shared_exclusive_lock_table_unit.sv
// Shared/exclusive lock table: top level with the item and blocked tables
// and the request sequencer. Depends on selt_pkg.
//
// Usage: a request word (in_opcode, in_transaction_id, in_item_id) is taken
// on the in_ channel when in_valid and in_ready are high. Shared and
// exclusive requests return one verdict word on the out_ channel (granted,
// denied, ignored); an end-of-case word and the unused opcode return none.
// Each lock request is decided in the ST_EVAL state: the accept edge reads the
// item record and the blocked bit from their tables (registered read); the
// decision then writes back the item table or the blocked table, as the case
// needs, and loads the output register. out_valid and in_ready both rise at
// the decision edge, so a new request is taken only once the last is decided.
// After reset, and after every end-of-case word, a clearing pass sweeps every
// entry of both tables, one entry a cycle, clearing the in-use and blocked
// bits; in_ready is low meanwhile.
// When the receiver stalls, the verdict holds in the output register; a
// next request may still be accepted, and its decision waits until the
// output register is free.
module shared_exclusive_lock_table_unit
  import selt_pkg::*;
#(
  parameter int ITEMS        = ITEMS_DEF,
  parameter int TRANSACTIONS = TRANSACTIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ID_W-1:0]      in_transaction_id,
  input  logic [ID_W-1:0]      in_item_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VERDICT_W-1:0] out_verdict
);

  localparam int IW   = $clog2(ITEMS);
  localparam int TW   = $clog2(TRANSACTIONS);
  localparam int MAXD = (ITEMS > TRANSACTIONS) ? ITEMS : TRANSACTIONS;
  localparam int CW   = $clog2(MAXD);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [OP_W-1:0]      op_r;
  logic [ID_W-1:0]      tr_r;
  logic [ID_W-1:0]      it_r;
  logic                 out_valid_r;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic                 out_load;

  // Tables and their registered read data
  item_rec_t            item_mem [ITEMS];
  logic                 blk_mem  [TRANSACTIONS];
  item_rec_t            item_rd_r;
  logic                 blk_rd_r;

  logic                 item_we, blk_we, blk_wd;
  logic [IW-1:0]        item_wa;
  logic [TW-1:0]        blk_wa;
  item_rec_t            item_wd;

  logic                 accept;
  logic [ID_EXT_W-1:0]  in_it_ext, in_tr_ext, it_ext, tr_ext;
  logic                 range_ok, sole, is_excl, out_free;
  logic                 cnt_in_items, cnt_in_trans;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Widen ids so a table depth of up to 2**17 entries can slice its index out of them
  assign in_it_ext = {{(ID_EXT_W-ID_W){1'b0}}, in_item_id};
  assign in_tr_ext = {{(ID_EXT_W-ID_W){1'b0}}, in_transaction_id};
  assign it_ext    = {{(ID_EXT_W-ID_W){1'b0}}, it_r};
  assign tr_ext    = {{(ID_EXT_W-ID_W){1'b0}}, tr_r};

  assign range_ok = ({{(32-ID_W){1'b0}}, it_r} < 32'(ITEMS)) &&
                    ({{(32-ID_W){1'b0}}, tr_r} < 32'(TRANSACTIONS));
  assign sole     = (item_rd_r.owner == {1'b0, tr_r});
  assign is_excl  = (op_r == OP_EXCL);

  assign cnt_in_items = ({{(32-CW){1'b0}}, cnt_r} < 32'(ITEMS));
  assign cnt_in_trans = ({{(32-CW){1'b0}}, cnt_r} < 32'(TRANSACTIONS));

  // Sequencer and decision
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    item_we     = 1'b0;
    item_wa     = it_ext[IW-1:0];
    item_wd     = item_rd_r;
    blk_we      = 1'b0;
    blk_wa      = tr_ext[TW-1:0];
    blk_wd      = 1'b1;
    verdict_nxt = VERDICT_GRANTED;
    out_load    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // sweep one entry of each table per cycle
        item_we        = cnt_in_items;
        item_wa        = cnt_r[IW-1:0];
        item_wd        = '0;
        blk_we         = cnt_in_trans;
        blk_wa         = cnt_r[TW-1:0];
        blk_wd         = 1'b0;
        if (cnt_r == CW'(MAXD-1)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_END: begin
              state_nxt = ST_CLEAR;
              cnt_nxt   = '0;
            end
            OP_SHARED, OP_EXCL: state_nxt = ST_EVAL;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EVAL: begin
        // decide only when the output register can take the verdict
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (!range_ok) begin
            verdict_nxt = VERDICT_DENIED;
          end else if (blk_rd_r) begin
            verdict_nxt = VERDICT_IGNORED;
          end else if (!item_rd_r.in_use) begin
            item_we            = 1'b1;
            item_wd.in_use     = 1'b1;
            item_wd.has_excl   = is_excl;
            item_wd.has_shared = !is_excl;
            item_wd.owner      = {1'b0, tr_r};
          end else if (!item_rd_r.has_excl && !item_rd_r.has_shared) begin
            item_we            = 1'b1;
            item_wd.has_excl   = is_excl;
            item_wd.has_shared = !is_excl;
            item_wd.owner      = {1'b0, tr_r};
          end else if (!is_excl && !item_rd_r.has_excl) begin
            // shared on shared: mark several holders on a new one
            item_we = !sole;
            item_wd.owner = OWNER_SEVERAL;
          end else if (sole) begin
            item_we = 1'b1;
            if (is_excl) begin
              item_wd.has_excl = 1'b1;
            end else begin
              item_wd.has_shared = 1'b1;
            end
          end else begin
            blk_we      = 1'b1;
            verdict_nxt = VERDICT_DENIED;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request word and the verdict
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
      tr_r <= in_transaction_id;
      it_r <= in_item_id;
    end
    if (out_load) begin
      verdict_r <= verdict_nxt;
    end
  end

  // Item table: one write, one registered read at acceptance
  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_wa] <= item_wd;
    end
    if (accept) begin
      item_rd_r <= item_mem[in_it_ext[IW-1:0]];
    end
  end

  // Blocked table: one write, one registered read at acceptance
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    if (accept) begin
      blk_rd_r <= blk_mem[in_tr_ext[TW-1:0]];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

// File: sv/selt_checker.sv
// Port-level checks for the shared/exclusive lock table, bound to the top
// level. Depends on selt_pkg and shared_exclusive_lock_table_unit.
module selt_checker
  import selt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [OP_W-1:0]      in_opcode,
  input logic [ID_W-1:0]      in_transaction_id,
  input logic [ID_W-1:0]      in_item_id,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [VERDICT_W-1:0] out_verdict
);

  // Hold a stalled verdict word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict))
    else $error("stalled verdict word dropped or changed");

  // Only defined verdict codes leave the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_GRANTED) ||
                  (out_verdict == VERDICT_DENIED) ||
                  (out_verdict == VERDICT_IGNORED))
    else $error("undefined verdict code");

  // A lock request keeps the block busy for its decision cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_opcode == OP_SHARED) || (in_opcode == OP_EXCL))
    |=> !in_ready)
    else $error("request word accepted during decision cycle");

  // End of case starts a clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_END) |=> !in_ready)
    else $error("word accepted at start of clearing pass");

  // A request with a free output shows its verdict after the decision edge
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
    ((in_opcode == OP_SHARED) || (in_opcode == OP_EXCL)) |=> ##1 out_valid)
    else $error("verdict word missing after request");

endmodule

bind shared_exclusive_lock_table_unit selt_checker u_selt_checker (.*);

// File: tb/lock_table_checker.sv
// Checker for the shared/exclusive lock table: watches the request and verdict
// channels, predicts each verdict from its own copy of the lock tables and
// compares. Depends on selt_pkg.
module lock_table_checker
  import selt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ID_W-1:0]      in_transaction_id,
  input  logic [ID_W-1:0]      in_item_id,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [VERDICT_W-1:0] out_verdict,
  output int                   errors,
  output int                   verdicts_due,
  output int                   n_granted,
  output int                   n_denied,
  output int                   n_ignored
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted tables
  item_rec_t lock_rec [ITEMS_DEF];
  logic      tx_blocked [TRANSACTIONS_DEF];

  // Verdicts predicted but not yet seen on the out_ channel
  logic [VERDICT_W-1:0] verdict_q [$];

  // Decide one lock request and update the predicted tables
  function automatic logic [VERDICT_W-1:0] lock_verdict(
    input logic            excl,
    input logic [ID_W-1:0] tr,
    input logic [ID_W-1:0] it
  );
    logic sole;
    if (int'(it) >= ITEMS_DEF || int'(tr) >= TRANSACTIONS_DEF) return VERDICT_DENIED;
    if (tx_blocked[tr]) return VERDICT_IGNORED;
    // Free item: requester becomes the sole owner
    if (!lock_rec[it].in_use) begin
      lock_rec[it].in_use     = 1'b1;
      lock_rec[it].has_excl   = excl;
      lock_rec[it].has_shared = !excl;
      lock_rec[it].owner      = {1'b0, tr};
      return VERDICT_GRANTED;
    end
    sole = (lock_rec[it].owner == {1'b0, tr});
    // In use but holding no mode: take it over like a free item
    if (!lock_rec[it].has_excl && !lock_rec[it].has_shared) begin
      if (excl) lock_rec[it].has_excl = 1'b1;
      else lock_rec[it].has_shared = 1'b1;
      lock_rec[it].owner = {1'b0, tr};
      return VERDICT_GRANTED;
    end
    // Shared on shared: always granted, a second holder marks it as several
    if (!excl && !lock_rec[it].has_excl) begin
      if (!sole) lock_rec[it].owner = OWNER_SEVERAL;
      return VERDICT_GRANTED;
    end
    // Sole owner adds the requested mode
    if (sole) begin
      if (excl) lock_rec[it].has_excl = 1'b1;
      else lock_rec[it].has_shared = 1'b1;
      return VERDICT_GRANTED;
    end
    // Conflict: block the transaction until the end of the case
    tx_blocked[tr] = 1'b1;
    return VERDICT_DENIED;
  endfunction

  always @(posedge clk) begin
    logic [VERDICT_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < ITEMS_DEF; i++) lock_rec[i] = '0;
      for (int i = 0; i < TRANSACTIONS_DEF; i++) tx_blocked[i] = 1'b0;
      verdict_q.delete();
      errors       <= 0;
      verdicts_due <= 0;
      n_granted    <= 0;
      n_denied     <= 0;
      n_ignored    <= 0;
    end else begin
      // Predict on every accepted request word
      if (in_valid && in_ready) begin
        case (in_opcode)
          OP_END: begin
            for (int i = 0; i < ITEMS_DEF; i++) lock_rec[i].in_use = 1'b0;
            for (int i = 0; i < TRANSACTIONS_DEF; i++) tx_blocked[i] = 1'b0;
          end
          OP_SHARED, OP_EXCL: begin
            want = lock_verdict(in_opcode == OP_EXCL, in_transaction_id, in_item_id);
            verdict_q.push_back(want);
            n_granted <= n_granted + (want == VERDICT_GRANTED);
            n_denied  <= n_denied + (want == VERDICT_DENIED);
            n_ignored <= n_ignored + (want == VERDICT_IGNORED);
          end
          default: begin
            // unused opcode: drop the word
          end
        endcase
      end
      // Compare every accepted verdict word with the oldest prediction
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("out_verdict: expected none, actual %0d", out_verdict);
          errors <= errors + 1;
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want) begin
            $error("out_verdict: expected %0d, actual %0d", want, out_verdict);
            errors <= errors + 1;
          end
        end
      end
      verdicts_due <= verdict_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top of the lock table testbench: clock, reset, request stimulus, verdict
// back-pressure and the final verdict. Depends on selt_pkg, lock_table_checker
// and shared_exclusive_lock_table_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import selt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 950;
  localparam int HOLD_CYCLES  = 1500;
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_opcode = OP_SHARED;
  logic [ID_W-1:0]      in_transaction_id = '0;
  logic [ID_W-1:0]      in_item_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VERDICT_W-1:0] out_verdict;

  int   fail_count, verdicts_due, n_granted, n_denied, n_ignored;
  int   accepted = 0;
  int   cycles = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic calm;
  int   n_words = 0;
  int   n_ends = 0;
  int   n_unused = 0;

  always #1 clk = ~clk;

  shared_exclusive_lock_table_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_transaction_id (in_transaction_id),
    .in_item_id        (in_item_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict)
  );

  lock_table_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_transaction_id (in_transaction_id),
    .in_item_id        (in_item_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .errors            (fail_count),
    .verdicts_due      (verdicts_due),
    .n_granted         (n_granted),
    .n_denied          (n_denied),
    .n_ignored         (n_ignored)
  );

  // Count accepted request words; a window of them runs with no idling
  always @(posedge clk) begin
    if (in_valid && in_ready) accepted <= accepted + 1;
  end
  assign calm = (accepted >= 250) && (accepted < 420);

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stall the verdict channel at random, once for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= 600) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Offer one request word, idling at random first, and wait for acceptance
  task automatic send_word(
    input logic [OP_W-1:0] op,
    input logic [ID_W-1:0] tr,
    input logic [ID_W-1:0] it
  );
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_transaction_id <= tr;
    in_item_id        <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_UNUSED) n_unused++;
    else n_words++;
    if (op == OP_END) n_ends++;
  endtask

  task automatic send_noise();
    send_word(OP_W'($urandom_range(3)), ID_W'($urandom_range(1023)),
              ID_W'($urandom_range(1023)));
  endtask

  initial begin
    logic [ID_W-1:0] tr_pool [8];
    logic [ID_W-1:0] it_pool [8];
    int ntr, nit, nreq, excl_pct;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sharing, upgrades, conflicts, blocking, end of case, extremes
    send_word(OP_SHARED, 10'd0, 10'd0);
    send_word(OP_SHARED, 10'd1023, 10'd0);
    send_word(OP_SHARED, 10'd5, 10'd0);
    send_word(OP_EXCL, 10'd5, 10'd0);
    send_word(OP_SHARED, 10'd5, 10'd1023);
    send_word(OP_EXCL, 10'd1023, 10'd1023);
    send_word(OP_SHARED, 10'd1023, 10'd1023);
    send_word(OP_SHARED, 10'd0, 10'd1023);
    send_word(OP_EXCL, 10'd1023, 10'd1023);
    send_word(OP_UNUSED, 10'd1023, 10'd1023);
    send_word(OP_SHARED, 10'h155, 10'h2AA);
    send_word(OP_EXCL, 10'h155, 10'h2AA);
    send_word(OP_EXCL, 10'h2AA, 10'h2AA);
    send_word(OP_SHARED, 10'h2AA, 10'h155);
    send_word(OP_END, 10'h3FF, 10'h3FF);
    send_word(OP_SHARED, 10'd5, 10'd0);
    send_word(OP_EXCL, 10'd0, 10'h155);
    send_word(OP_SHARED, 10'd1023, 10'h155);
    send_word(OP_EXCL, 10'd0, 10'h155);
    send_word(OP_SHARED, 10'd0, 10'd0);
    send_word(OP_END, 10'h155, 10'h2AA);

    // Random: mostly cases of a few transactions fighting over a few items
    while (n_words < RANDOM_WORDS) begin
      if ($urandom_range(99) < 85) begin
        ntr      = $urandom_range(6, 2);
        nit      = $urandom_range(5, 1);
        nreq     = $urandom_range(40, 8);
        excl_pct = $urandom_range(70, 5);
        for (int k = 0; k < 8; k++) begin
          tr_pool[k] = ID_W'($urandom_range(1023));
          it_pool[k] = ID_W'($urandom_range(1023));
        end
        for (int k = 0; k < nreq; k++) begin
          if ($urandom_range(99) < 4) send_noise();
          else send_word(($urandom_range(99) < excl_pct) ? OP_EXCL : OP_SHARED,
                         tr_pool[$urandom_range(ntr - 1)], it_pool[$urandom_range(nit - 1)]);
        end
        send_word(OP_END, ID_W'($urandom_range(1023)), ID_W'($urandom_range(1023)));
      end else begin
        repeat ($urandom_range(12, 3)) send_noise();
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding verdicts, then let the block settle
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d request words (%0d end-of-case) and %0d unused-opcode words",
             n_words, n_ends, n_unused);
    $display("Verdicts checked: %0d granted, %0d denied, %0d ignored",
             n_granted, n_denied, n_ignored);
    if (fail_count == 0 && verdicts_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
